### hw/rtl/mtfd_pkg.sv
// shared constants and types for the thresholded frame difference mean block
package mtfd_pkg;

  // default sizes for the top level parameters
  localparam int MAX_PIXELS_DEF = 65536;
  localparam int SUM_BITS_DEF   = 16;

  // fixed field widths
  localparam int PIX_W      = 8;
  localparam int MEAN_W     = 8;
  localparam int CNT_W      = 16;
  localparam int FP_W       = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_INPUT    = 2'd0,
    CFG_FRAME_PIXELS   = 2'd1,
    CFG_DIFF_THRESHOLD = 2'd2
  } cfg_idx_e;

  // configuration reset values
  localparam logic            COLOR_RST = 1'b1;
  localparam logic [FP_W-1:0] FP_RST    = 17'd65536;
  localparam logic [PIX_W-1:0] THR_RST  = 8'd10;

  // gray conversion weights, fixed point with 14 fractional bits
  localparam int            GRAY_SHIFT = 14;
  localparam int            GRAY_SUM_W = 22;
  localparam logic [13:0]   GRAY_WB    = 14'd1868;
  localparam logic [13:0]   GRAY_WG    = 14'd9617;
  localparam logic [13:0]   GRAY_WR    = 14'd4899;
  localparam logic [13:0]   GRAY_RND   = 14'd8192;

  // frame counter saturation value
  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  // largest mean value
  localparam logic [MEAN_W-1:0] MEAN_MAX = 8'hFF;

endpackage

### hw/rtl/mean_thresholded_frame_difference_top.sv
// pipelined temporal mean of thresholded gray frame differences
// after its input transfer, a result passes stage a, stage b, stage c, the divider stages and the output register
// throughput: one pixel per cycle while the output is not held; the pixel store is one read and one write port,
//   with a bypass from the stage c registers for one-pixel frames
// a held output stalls every stage at once, nothing is dropped or repeated
// reset clears valid bits, counters and config; the pixel store needs no clearing
module mean_thresholded_frame_difference_top
  import mtfd_pkg::*;
#(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF,
  parameter int SUM_BITS   = SUM_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,

  // pixel input
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,  // blue, green, red
  input  logic                  s_axis_tuser,  // last_frame

  // mean output
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,  // mean_value
  output logic                  m_axis_tlast   // last_pixel
);

  localparam int IDX_W  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int NW     = (IDX_W + 1 > FP_W) ? IDX_W + 1 : FP_W;
  localparam int DIV_W  = (SUM_BITS > CNT_W + MEAN_W) ? SUM_BITS : CNT_W + MEAN_W;
  localparam int DSTEPS = MEAN_W;

  // configuration registers
  logic              color_q;
  logic [FP_W-1:0]   frame_pixels_q;
  logic [PIX_W-1:0]  thr_q;
  logic [NW-1:0]     n_m1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q        <= COLOR_RST;
      frame_pixels_q <= FP_RST;
      thr_q          <= THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_COLOR_INPUT:    color_q        <= cfg_data_i[0];
        CFG_FRAME_PIXELS:   frame_pixels_q <= cfg_data_i[FP_W-1:0];
        CFG_DIFF_THRESHOLD: thr_q          <= cfg_data_i[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // last pixel position of a frame, with the frame size clamped to 1..MAX_PIXELS
  always_comb begin
    n_m1 = NW'(frame_pixels_q) - NW'(1);
    if (frame_pixels_q == '0) begin
      n_m1 = '0;
    end else if (NW'(frame_pixels_q) > NW'(MAX_PIXELS)) begin
      n_m1 = NW'(MAX_PIXELS - 1);
    end
  end

  // whole pipeline advances when the output register is free or being drained
  logic en;
  logic out_valid_q;
  logic in_xfer;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign in_xfer       = s_axis_tvalid && en;

  // position and frame counters, updated at each input transfer
  logic [IDX_W-1:0] pix_idx_q, pix_idx_d;
  logic [CNT_W-1:0] frame_cnt_q, frame_cnt_d;
  logic             eof;

  always_comb begin
    eof         = NW'(pix_idx_q) >= n_m1;
    pix_idx_d   = pix_idx_q + IDX_W'(1);
    frame_cnt_d = frame_cnt_q;
    if (eof) begin
      pix_idx_d = '0;
      if (s_axis_tuser) begin
        frame_cnt_d = '0;
      end else if (frame_cnt_q != CNT_MAX) begin
        frame_cnt_d = frame_cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_idx_q   <= '0;
      frame_cnt_q <= '0;
    end else if (in_xfer) begin
      pix_idx_q   <= pix_idx_d;
      frame_cnt_q <= frame_cnt_d;
    end
  end

  // stage a: registered input
  logic             a_vld_q;
  logic [PIX_W-1:0] a_b_q, a_g_q, a_r_q;
  logic             a_lf_q, a_eof_q;
  logic [IDX_W-1:0] a_idx_q;
  logic [CNT_W-1:0] a_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_b_q   <= s_axis_tdata[7:0];
      a_g_q   <= s_axis_tdata[15:8];
      a_r_q   <= s_axis_tdata[23:16];
      a_lf_q  <= s_axis_tuser;
      a_eof_q <= eof;
      a_idx_q <= pix_idx_q;
      a_cnt_q <= frame_cnt_q;
    end
  end

  // gray conversion
  logic [GRAY_SUM_W-1:0] gray_sum;
  logic [PIX_W-1:0]      a_gray;

  always_comb begin
    gray_sum = GRAY_SUM_W'(a_b_q) * GRAY_SUM_W'(GRAY_WB)
             + GRAY_SUM_W'(a_g_q) * GRAY_SUM_W'(GRAY_WG)
             + GRAY_SUM_W'(a_r_q) * GRAY_SUM_W'(GRAY_WR)
             + GRAY_SUM_W'(GRAY_RND);
    a_gray   = color_q ? gray_sum[GRAY_SUM_W-1:GRAY_SHIFT] : a_b_q;
  end

  // pixel store: previous gray and running sum per pixel position
  logic [PIX_W-1:0]    prev_mem [MAX_PIXELS];
  logic [SUM_BITS-1:0] sum_mem  [MAX_PIXELS];
  logic [PIX_W-1:0]    rd_prev_q;
  logic [SUM_BITS-1:0] rd_sum_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_prev_q <= prev_mem[a_idx_q];
      rd_sum_q  <= sum_mem[a_idx_q];
    end
  end

  // stage b: gray value with store read data
  logic             b_vld_q;
  logic [PIX_W-1:0] b_gray_q;
  logic             b_lf_q, b_eof_q;
  logic [IDX_W-1:0] b_idx_q;
  logic [CNT_W-1:0] b_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_gray_q <= a_gray;
      b_lf_q   <= a_lf_q;
      b_eof_q  <= a_eof_q;
      b_idx_q  <= a_idx_q;
      b_cnt_q  <= a_cnt_q;
    end
  end

  // stage c registers, also the bypass source for the store
  logic                c_vld_q;
  logic [PIX_W-1:0]    c_gray_q;
  logic [SUM_BITS-1:0] c_sum_q;
  logic                c_lf_q, c_eof_q;
  logic [IDX_W-1:0]    c_idx_q;
  logic [CNT_W-1:0]    c_cnt_q;

  // thresholded difference and saturating accumulate, the sum cleared while the frame count is zero
  logic                fwd;
  logic [PIX_W-1:0]    prev_gray, diff, diff_thr;
  logic [SUM_BITS-1:0] prev_sum, b_sum;
  logic [SUM_BITS:0]   sum_wide;

  always_comb begin
    fwd       = c_vld_q && (c_idx_q == b_idx_q);
    prev_gray = fwd ? c_gray_q : rd_prev_q;
    prev_sum  = fwd ? c_sum_q  : rd_sum_q;
    diff      = (b_gray_q > prev_gray) ? b_gray_q - prev_gray : prev_gray - b_gray_q;
    diff_thr  = (diff <= thr_q) ? '0 : diff;
    sum_wide  = {1'b0, prev_sum} + (SUM_BITS+1)'(diff_thr);
    b_sum     = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
    if (b_cnt_q == '0) begin
      b_sum = '0;
    end
  end

  // store write-back
  always_ff @(posedge clk_i) begin
    if (en && b_vld_q) begin
      prev_mem[b_idx_q] <= b_gray_q;
      sum_mem[b_idx_q]  <= b_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_gray_q <= b_gray_q;
      c_sum_q  <= b_sum;
      c_lf_q   <= b_lf_q;
      c_eof_q  <= b_eof_q;
      c_idx_q  <= b_idx_q;
      c_cnt_q  <= b_cnt_q;
    end
  end

  // divider stages, one quotient bit per stage, only result-bearing items stay valid
  logic              dv_vld_q  [DSTEPS+1];
  logic [DIV_W-1:0]  dv_rem_q  [DSTEPS+1];
  logic [CNT_W-1:0]  dv_den_q  [DSTEPS+1];
  logic [MEAN_W-1:0] dv_quo_q  [DSTEPS+1];
  logic              dv_sat_q  [DSTEPS+1];
  logic              dv_last_q [DSTEPS+1];
  logic [DIV_W-1:0]  dv_shift  [DSTEPS];
  logic              dv_take   [DSTEPS];
  logic [DIV_W-1:0]  dv_rem_d  [DSTEPS];
  logic [MEAN_W-1:0] dv_quo_d  [DSTEPS];

  // trial subtraction of the shifted divisor in each stage
  always_comb begin
    for (int j = 0; j < DSTEPS; j++) begin
      dv_shift[j]             = DIV_W'(dv_den_q[j]) << (DSTEPS - 1 - j);
      dv_take[j]              = dv_rem_q[j] >= dv_shift[j];
      dv_rem_d[j]             = dv_take[j] ? dv_rem_q[j] - dv_shift[j] : dv_rem_q[j];
      dv_quo_d[j]             = dv_quo_q[j];
      dv_quo_d[j][DSTEPS-1-j] = dv_take[j];
    end
  end

  // divider valid bits, the first stage keeps only result-bearing items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DSTEPS; k++) begin
        dv_vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      dv_vld_q[0] <= c_vld_q && c_lf_q;
      for (int k = 0; k < DSTEPS; k++) begin
        dv_vld_q[k+1] <= dv_vld_q[k];
      end
    end
  end

  // divider data, first stage also checks for quotient overflow
  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_rem_q[0]  <= DIV_W'(c_sum_q);
      dv_den_q[0]  <= c_cnt_q;
      dv_quo_q[0]  <= '0;
      dv_sat_q[0]  <= DIV_W'(c_sum_q) >= DIV_W'({c_cnt_q, {MEAN_W{1'b0}}});
      dv_last_q[0] <= c_eof_q;
      for (int k = 0; k < DSTEPS; k++) begin
        dv_rem_q[k+1]  <= dv_rem_d[k];
        dv_quo_q[k+1]  <= dv_quo_d[k];
        dv_den_q[k+1]  <= dv_den_q[k];
        dv_sat_q[k+1]  <= dv_sat_q[k];
        dv_last_q[k+1] <= dv_last_q[k];
      end
    end
  end

  // round half to even and clamp
  logic [CNT_W:0]    rem2;
  logic              rnd_up;
  logic [MEAN_W-1:0] mean_d;

  always_comb begin
    rem2   = {dv_rem_q[DSTEPS][CNT_W-1:0], 1'b0};
    rnd_up = (rem2 > {1'b0, dv_den_q[DSTEPS]})
          || ((rem2 == {1'b0, dv_den_q[DSTEPS]}) && dv_quo_q[DSTEPS][0]);
    mean_d = dv_quo_q[DSTEPS];
    if (rnd_up && (dv_quo_q[DSTEPS] != MEAN_MAX)) begin
      mean_d = dv_quo_q[DSTEPS] + MEAN_W'(1);
    end
    if (dv_sat_q[DSTEPS]) begin
      mean_d = MEAN_MAX;
    end
    if (dv_den_q[DSTEPS] == '0) begin
      mean_d = '0;
    end
  end

  // output register
  logic [MEAN_W-1:0] out_mean_q;
  logic              out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_vld_q[DSTEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_mean_q <= mean_d;
      out_last_q <= dv_last_q[DSTEPS];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_mean_q;
  assign m_axis_tlast  = out_last_q;

endmodule
